// ===== sv/tgc_pkg.sv =====
// Shared constants, codes and types of the touch gesture classifier.
package tgc_pkg;

  localparam logic [7:0] RAW_X_MAX     = 8'd239;
  localparam logic [8:0] RAW_Y_MAX     = 9'd319;
  localparam logic [8:0] SCREEN_X_MAX  = 9'd320;
  localparam int         STILL_PX      = 10;
  localparam logic [17:0] STILL_SQ     = 18'(STILL_PX * STILL_PX);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MAX = 2'd3;

  localparam logic [15:0] TAP_MAX_RST   = 16'd300;
  localparam logic [15:0] HOLD_MIN_RST  = 16'd800;
  localparam logic [8:0]  SWIPE_MIN_RST = 9'd30;
  localparam logic [15:0] SWIPE_MAX_RST = 16'd500;

  localparam logic [2:0] G_NONE  = 3'd0;
  localparam logic [2:0] G_TAP   = 3'd1;
  localparam logic [2:0] G_HOLD  = 3'd2;
  localparam logic [2:0] G_RIGHT = 3'd3;
  localparam logic [2:0] G_LEFT  = 3'd4;
  localparam logic [2:0] G_DOWN  = 3'd5;
  localparam logic [2:0] G_UP    = 3'd6;

  typedef struct packed {
    logic [15:0] tap_max;
    logic [15:0] hold_min;
    logic [17:0] swipe_min_sq;
    logic [15:0] swipe_max;
  } tgc_cfg_t;

  typedef struct packed {
    logic [8:0] start_x;
    logic [7:0] start_y;
    logic [8:0] last_x;
    logic [7:0] last_y;
  } tgc_track_t;

endpackage

// ===== sv/tgc_classify.sv =====
// Lift-time classification of one touch from its duration and displacement.
module tgc_classify import tgc_pkg::*; (
  input  tgc_track_t  track,
  input  tgc_cfg_t    cfg,
  input  logic [31:0] duration,
  output logic [2:0]  code
);

  logic [9:0]  dx;
  logic [8:0]  dy;
  logic [9:0]  dx_mag;
  logic [8:0]  dy_mag;
  logic [8:0]  ax;
  logic [7:0]  ay;
  logic [17:0] sq_x;
  logic [15:0] sq_y;
  logic [17:0] d2;
  logic        still;
  logic        far;

  assign dx     = {1'b0, track.last_x} - {1'b0, track.start_x};
  assign dy     = {1'b0, track.last_y} - {1'b0, track.start_y};
  assign dx_mag = dx[9] ? (~dx + 10'd1) : dx;
  assign dy_mag = dy[8] ? (~dy + 9'd1) : dy;
  assign ax     = dx_mag[8:0];
  assign ay     = dy_mag[7:0];
  assign sq_x   = {9'd0, ax} * {9'd0, ax};
  assign sq_y   = {8'd0, ay} * {8'd0, ay};
  // Squared distance compares stand in for the rounded-down root.
  assign d2     = sq_x + {2'b00, sq_y};
  assign still  = d2 < STILL_SQ;
  assign far    = d2 >= cfg.swipe_min_sq;

  always_comb begin
    if (still && (duration < {16'd0, cfg.tap_max})) begin
      code = G_TAP;
    end else if (still && (duration >= {16'd0, cfg.hold_min})) begin
      code = G_HOLD;
    end else if (far && (duration < {16'd0, cfg.swipe_max})) begin
      if (ax > {1'b0, ay}) begin
        code = (!dx[9] && (dx != 10'd0)) ? G_RIGHT : G_LEFT;
      end else begin
        code = (!dy[8] && (dy != 9'd0)) ? G_DOWN : G_UP;
      end
    end else begin
      code = G_NONE;
    end
  end

endmodule

// ===== sv/touch_gesture_classifier.sv =====
// Top level of the touch gesture classifier: poll register, touch tracking, result register.
//
// Each input beat is one touch-panel poll: a touched flag, raw portrait
// coordinates and a millisecond timestamp. Every poll yields exactly one
// output beat carrying the finger-down flag, the latest landscape point and,
// on the poll where the finger lifts, a valid gesture code (tap, hold, a
// swipe direction, or none when no gesture matches).
// The block is a two-register pipeline. A poll is captured in the input
// register on the edge where in_valid and in_ready are both high; once the
// output register is free or being taken, the clamping, rotation, tracking
// update and classification are done in one pass and the result is written
// to the output register. One poll per cycle is taken when the receiver keeps
// out_ready high; the single pass through the squaring and compare logic
// only bounds the clock rate, not the poll rate.
// When the receiver stalls, the result stays in the output register and the
// poll behind it waits in the input register; in_ready falls only once both
// are full, so no beat is lost or repeated.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect on the edge
// they are presented and should only be issued while the block is idle.
// Synchronous reset clears both valid flags, the touch state and the tracked
// points, and restores the default thresholds.
module touch_gesture_classifier import tgc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_touch_present,
  input  logic [7:0]            in_raw_x,
  input  logic [8:0]            in_raw_y,
  input  logic [31:0]           in_time_ms,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_finger_down,
  output logic [8:0]            out_point_x,
  output logic [7:0]            out_point_y,
  output logic                  out_gesture_valid,
  output logic [2:0]            out_gesture_code
);

  // Configuration registers; the swipe distance is kept squared so that the
  // classifier only compares.
  tgc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_max      <= TAP_MAX_RST;
      cfg_r.hold_min     <= HOLD_MIN_RST;
      cfg_r.swipe_min_sq <= {9'd0, SWIPE_MIN_RST} * {9'd0, SWIPE_MIN_RST};
      cfg_r.swipe_max    <= SWIPE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_MAX:   cfg_r.tap_max      <= cfg_wdata;
        CFG_HOLD_MIN:  cfg_r.hold_min     <= cfg_wdata;
        CFG_SWIPE_MIN: cfg_r.swipe_min_sq <= {9'd0, cfg_wdata[8:0]} * {9'd0, cfg_wdata[8:0]};
        CFG_SWIPE_MAX: cfg_r.swipe_max    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  logic        s1_valid_r;
  logic        s1_present_r;
  logic [7:0]  s1_rx_r;
  logic [8:0]  s1_ry_r;
  logic [31:0] s1_time_r;

  logic advance;
  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_present_r <= in_touch_present;
      s1_rx_r      <= in_raw_x;
      s1_ry_r      <= in_raw_y;
      s1_time_r    <= in_time_ms;
    end
  end

  // Clamp and rotate into landscape screen pixels.
  logic [7:0] rx_c;
  logic [8:0] ry_c;
  logic [8:0] px;
  logic [7:0] py;

  assign rx_c = (s1_rx_r > RAW_X_MAX) ? RAW_X_MAX : s1_rx_r;
  assign ry_c = (s1_ry_r > RAW_Y_MAX) ? RAW_Y_MAX : s1_ry_r;
  assign px   = SCREEN_X_MAX - ry_c;
  assign py   = rx_c;

  // Touch tracking state.
  logic        touch_active_r, touch_active_nxt;
  tgc_track_t  track_r, track_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic        lift;
  logic [31:0] duration;
  logic [2:0]  code;

  assign lift     = !s1_present_r && touch_active_r;
  assign duration = s1_time_r - start_time_r;

  tgc_classify u_classify (
    .track    (track_r),
    .cfg      (cfg_r),
    .duration (duration),
    .code     (code)
  );

  always_comb begin
    touch_active_nxt = touch_active_r;
    track_nxt        = track_r;
    start_time_nxt   = start_time_r;
    if (s1_present_r) begin
      if (!touch_active_r) begin
        // Touch-down: the start point and time are latched.
        touch_active_nxt  = 1'b1;
        track_nxt.start_x = px;
        track_nxt.start_y = py;
        start_time_nxt    = s1_time_r;
      end
      track_nxt.last_x = px;
      track_nxt.last_y = py;
    end else if (touch_active_r) begin
      touch_active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_active_r <= 1'b0;
      track_r        <= '0;
      start_time_r   <= '0;
    end else if (advance) begin
      touch_active_r <= touch_active_nxt;
      track_r        <= track_nxt;
      start_time_r   <= start_time_nxt;
    end
  end

  // Result register.
  logic       out_valid_r;
  logic       out_finger_down_r;
  logic [8:0] out_point_x_r;
  logic [7:0] out_point_y_r;
  logic       out_gesture_valid_r;
  logic [2:0] out_gesture_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_finger_down_r   <= touch_active_nxt;
      out_point_x_r       <= track_nxt.last_x;
      out_point_y_r       <= track_nxt.last_y;
      out_gesture_valid_r <= lift;
      out_gesture_code_r  <= lift ? code : G_NONE;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_finger_down   = out_finger_down_r;
  assign out_point_x       = out_point_x_r;
  assign out_point_y       = out_point_y_r;
  assign out_gesture_valid = out_gesture_valid_r;
  assign out_gesture_code  = out_gesture_code_r;

  // A lift result never reports the finger as still down.
  a_lift_not_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_gesture_valid) |-> !out_finger_down)
    else $error("gesture reported while finger still down");

  // Polls without a lift carry no gesture code.
  a_code_only_on_lift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_gesture_valid) |-> (out_gesture_code == G_NONE))
    else $error("gesture code set without a lift");

  // On touch-down the start and latest points coincide.
  a_down_latch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(touch_active_r) |->
      (track_r.start_x == track_r.last_x) && (track_r.start_y == track_r.last_y))
    else $error("start point not latched on touch-down");

  // Mapped points stay on the landscape screen.
  a_point_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_x <= SCREEN_X_MAX) && (out_point_y <= RAW_X_MAX))
    else $error("mapped point off screen");

endmodule
